### design/shortest_burst_cpu_scheduler_defines.svh
// Assertion macros used by the scheduler's I/O queue.
`ifndef SHORTEST_BURST_CPU_SCHEDULER_DEFINES_SVH
`define SHORTEST_BURST_CPU_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SBCS_ASSERT_NOW(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBCS_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

### design/sbcs_pkg.sv
// Shared types and codes for the shortest-burst CPU scheduler.
package sbcs_pkg;

  localparam logic [1:0] REQ_HEADER = 2'd0;
  localparam logic [1:0] REQ_BURST  = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic CFG_PREEMPT    = 1'b0;
  localparam logic CFG_PROC_COUNT = 1'b1;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

### design/sbcs_burst_mem.sv
// Burst table memory: one write port, one registered read port.
module sbcs_burst_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/sbcs_io_queue.sv
// I/O wait queue: FIFO of slot numbers with wrap-bit head and tail pointers.
`include "shortest_burst_cpu_scheduler_defines.svh"

module sbcs_io_queue #(
  parameter int DEPTH = 16,
  parameter int SW    = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  sbcs_pkg::q_ctl_t ctl,
  input  logic [SW-1:0]    push_slot,
  output sbcs_pkg::q_stat_t stat,
  output logic [SW-1:0]    head_slot
);

  localparam int QW = $clog2(2 * DEPTH);
  localparam int FW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [QW-1:0] head;
  logic [QW-1:0] tail;
  logic [QW:0]   qlen;
  logic [FW-1:0] head_idx;
  logic [FW-1:0] tail_idx;
  logic [SW-1:0] fifo [DEPTH];

  function automatic logic [QW-1:0] wrap_inc(input logic [QW-1:0] p);
    return (32'(p) == 2 * DEPTH - 1) ? '0 : QW'(p + 1'b1);
  endfunction

  function automatic logic [FW-1:0] to_idx(input logic [QW-1:0] p);
    return (32'(p) >= DEPTH) ? FW'(32'(p) - DEPTH) : FW'(p);
  endfunction

  assign head_idx = to_idx(head);
  assign tail_idx = to_idx(tail);
  assign qlen = (tail >= head) ? (QW + 1)'(tail - head)
                               : (QW + 1)'((QW + 1)'(tail) + (QW + 1)'(2 * DEPTH) - head);
  assign stat.empty = (qlen == '0);
  assign stat.full  = (32'(qlen) == DEPTH);
  assign head_slot  = fifo[head_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (ctl.push) begin
        tail <= wrap_inc(tail);
      end
      if (ctl.pop) begin
        head <= wrap_inc(head);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      fifo[tail_idx] <= push_slot;
    end
  end

  `SBCS_ASSERT_NOW(a_len_bound, 1'b1, 32'(qlen) <= DEPTH, "io queue length over depth")
  `SBCS_ASSERT_NOW(a_no_push_full, ctl.push, !stat.full, "push into full io queue")
  `SBCS_ASSERT_NOW(a_no_pop_empty, ctl.pop, !stat.empty, "pop from empty io queue")
  `SBCS_ASSERT_NEXT(a_push_fills, ctl.push && !ctl.pop, !stat.empty, "queue empty after push")

endmodule

### design/shortest_burst_cpu_scheduler.sv
// Shortest-burst-first scheduler: per-tick slot scan, I/O queue service, CPU update.
// Header and burst loads give no result.
// A tick scans the used slots one by one through the burst memory, then runs the I/O head and
// runner read-modify-write steps.
// The result word is registered; the next item is taken once the tick is finished.
// Synchronous reset clears pointers, sets ready flags, empties the queue; no clearing pass.
module shortest_burst_cpu_scheduler #(
  parameter int MAX_PROCS      = 16,
  parameter int MAX_BURSTS     = 128,
  parameter int IO_QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [3:0]  slot,
  input  logic [6:0]  burst_index,
  input  logic [15:0] burst_value,
  input  logic [15:0] arrival_time,
  input  logic [7:0]  proc_label,
  input  logic [7:0]  burst_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        cpu_busy,
  output logic [7:0]  run_label,
  output logic        segment_end,
  output logic [7:0]  segment_label,
  output logic [15:0] segment_length,
  output logic        all_done
);

  localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RW = $clog2(MAX_PROCS + 1);
  localparam int PW = $clog2(MAX_BURSTS + 1);
  localparam int AW = $clog2(MAX_PROCS * MAX_BURSTS);
  localparam logic [RW-1:0] IDLE_SLOT = RW'(MAX_PROCS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SEG   = 3'd2;
  localparam logic [2:0] S_IOCHK = 3'd3;
  localparam logic [2:0] S_IORD  = 3'd4;
  localparam logic [2:0] S_CPU   = 3'd5;
  localparam logic [2:0] S_CPURD = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  function automatic logic [AW-1:0] baddr(input logic [SW-1:0] s, input logic [PW-1:0] p);
    return AW'(AW'(s) * AW'(MAX_BURSTS) + AW'(p));
  endfunction

  // per-slot records
  logic [PW-1:0]        ptr     [MAX_PROCS];
  logic [PW-1:0]        total   [MAX_PROCS];
  logic [15:0]          arrival [MAX_PROCS];
  logic [7:0]           label   [MAX_PROCS];
  logic [MAX_PROCS-1:0] ready;

  logic [2:0]    state;
  logic          preempt;
  logic [4:0]    proc_count;
  logic [RW-1:0] scan_i;
  logic          pend_v;
  logic [RW-1:0] pend_slot;
  logic [RW-1:0] best;
  logic [15:0]   min_burst;
  logic          has_any;
  logic          second;
  logic [RW-1:0] runner;
  logic [15:0]   run_ticks;
  logic          cpu_live;
  logic [15:0]   tick_count;
  logic [AW-1:0] io_addr;
  logic [AW-1:0] cpu_addr;

  logic        r_busy;
  logic [7:0]  r_label;
  logic        r_seg;
  logic [7:0]  r_seg_label;
  logic [15:0] r_seg_len;
  logic        r_done;

  logic [RW-1:0] n_used;
  logic [SW-1:0] rec_addr;
  logic [PW-1:0] rec_ptr;
  logic [PW-1:0] rec_total;
  logic [15:0]   rec_arr;
  logic [7:0]    rec_label;
  logic          rec_ready;
  logic          rec_has;
  logic          elig;
  logic          hold;
  logic [RW-1:0] pick;
  logic          in_acc;
  logic          load_ok;
  logic [PW:0]   p1;
  logic [15:0]   nv;
  logic          cpu_end;
  logic          can_queue;

  logic          ptr_we;
  logic [PW-1:0] ptr_wdata;
  logic          ready_we;
  logic          ready_wdata;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  sbcs_pkg::q_ctl_t  q_ctl;
  sbcs_pkg::q_stat_t q_stat;
  logic [SW-1:0]     q_head;

  sbcs_burst_mem #(
    .DEPTH(MAX_PROCS * MAX_BURSTS),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  sbcs_io_queue #(
    .DEPTH(IO_QUEUE_DEPTH),
    .SW   (SW)
  ) u_ioq (
    .clk      (clk),
    .rst      (rst),
    .ctl      (q_ctl),
    .push_slot(runner[SW-1:0]),
    .stat     (q_stat),
    .head_slot(q_head)
  );

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign load_ok  = (32'(slot) < MAX_PROCS);
  assign n_used   = (32'(proc_count) > MAX_PROCS) ? IDLE_SLOT : RW'(proc_count);

  always_comb begin
    case (state)
      S_IDLE:               rec_addr = SW'(slot);
      S_SCAN:               rec_addr = scan_i[SW-1:0];
      S_IOCHK, S_IORD:      rec_addr = q_head;
      default:              rec_addr = runner[SW-1:0];
    endcase
  end

  assign rec_ptr   = ptr[rec_addr];
  assign rec_total = total[rec_addr];
  assign rec_arr   = arrival[rec_addr];
  assign rec_label = label[rec_addr];
  assign rec_ready = ready[rec_addr];
  assign rec_has   = (rec_ptr < rec_total);
  assign elig      = (rec_arr <= tick_count) && rec_ready && rec_has;
  assign hold      = !preempt && cpu_live && (runner != IDLE_SLOT);
  assign pick      = hold ? runner : best;

  assign nv        = (mem_rdata == '0) ? '0 : mem_rdata - 16'd1;
  assign cpu_end   = (nv == '0);
  assign p1        = (PW + 1)'(rec_ptr) + 1'b1;
  assign can_queue = (p1 < (PW + 1)'(rec_total));

  // queue control
  always_comb begin
    q_ctl.pop  = 1'b0;
    q_ctl.push = 1'b0;
    if (state == S_IOCHK) begin
      q_ctl.pop = !q_stat.empty && !rec_has && !second;
    end else if (state == S_IORD) begin
      q_ctl.pop = ((mem_rdata == '0) && !second) || (mem_rdata == 16'd1);
    end else if (state == S_CPURD) begin
      q_ctl.push = cpu_end && can_queue && !q_stat.full;
    end
  end

  // slot record updates
  always_comb begin
    ptr_we      = 1'b0;
    ptr_wdata   = rec_ptr;
    ready_we    = 1'b0;
    ready_wdata = 1'b1;
    if (state == S_IDLE) begin
      if (in_acc && req_type == sbcs_pkg::REQ_HEADER && load_ok) begin
        ptr_we    = 1'b1;
        ptr_wdata = '0;
        ready_we  = 1'b1;
      end
    end else if (q_ctl.pop) begin
      ready_we  = 1'b1;
      ptr_we    = rec_has;
      ptr_wdata = PW'(p1);
    end else if (state == S_CPURD && cpu_end) begin
      ptr_we = 1'b1;
      if (can_queue && q_stat.full) begin
        ptr_wdata = PW'(p1 + 1'b1);
      end else begin
        ptr_wdata = PW'(p1);
      end
      if (can_queue && !q_stat.full) begin
        ready_we    = 1'b1;
        ready_wdata = 1'b0;
      end
    end
  end

  // burst memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = io_addr;
    mem_wdata = mem_rdata - 16'd1;
    case (state)
      S_IDLE: begin
        mem_we    = in_acc && req_type == sbcs_pkg::REQ_BURST && load_ok &&
                    (32'(burst_index) < MAX_BURSTS);
        mem_waddr = AW'(AW'(SW'(slot)) * AW'(MAX_BURSTS) + AW'(burst_index));
        mem_wdata = burst_value;
      end
      S_IORD: begin
        mem_we = (mem_rdata != '0);
      end
      S_CPURD: begin
        mem_we    = 1'b1;
        mem_waddr = cpu_addr;
        mem_wdata = nv;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_raddr = baddr(rec_addr, rec_ptr);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        ptr[i] <= '0;
      end
      ready <= '1;
    end else begin
      if (ptr_we) begin
        ptr[rec_addr] <= ptr_wdata;
      end
      if (ready_we) begin
        ready[rec_addr] <= ready_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc && req_type == sbcs_pkg::REQ_HEADER && load_ok) begin
      arrival[rec_addr] <= arrival_time;
      label[rec_addr]   <= proc_label;
      total[rec_addr]   <= (32'(burst_count) > MAX_BURSTS) ? PW'(MAX_BURSTS)
                                                            : PW'(burst_count);
    end
  end

  // tick sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      preempt    <= 1'b1;
      proc_count <= '0;
      scan_i     <= '0;
      pend_v     <= 1'b0;
      best       <= IDLE_SLOT;
      has_any    <= 1'b0;
      second     <= 1'b0;
      runner     <= IDLE_SLOT;
      run_ticks  <= '0;
      cpu_live   <= 1'b0;
      tick_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == sbcs_pkg::CFG_PREEMPT) begin
          preempt <= cfg_data[0];
        end else begin
          proc_count <= cfg_data;
        end
      end
      // load the finished word, or drop the one just taken
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && req_type == sbcs_pkg::REQ_TICK) begin
            scan_i  <= '0;
            pend_v  <= 1'b0;
            best    <= IDLE_SLOT;
            has_any <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (pend_v && (best == IDLE_SLOT || mem_rdata < min_burst)) begin
            best      <= pend_slot;
            min_burst <= mem_rdata;
          end
          if (scan_i < n_used) begin
            pend_v    <= elig;
            pend_slot <= scan_i;
            has_any   <= has_any | rec_has;
            scan_i    <= scan_i + 1'b1;
          end else begin
            pend_v <= 1'b0;
            state  <= S_SEG;
          end
        end
        S_SEG: begin
          if (runner != IDLE_SLOT && pick != runner) begin
            r_seg       <= 1'b1;
            r_seg_label <= rec_label;
            r_seg_len   <= run_ticks;
            run_ticks   <= '0;
          end else begin
            r_seg       <= 1'b0;
            r_seg_label <= '0;
            r_seg_len   <= '0;
          end
          runner <= pick;
          r_done <= !has_any;
          second <= 1'b0;
          state  <= S_IOCHK;
        end
        S_IOCHK: begin
          if (q_stat.empty) begin
            state <= S_CPU;
          end else if (!rec_has) begin
            // released without an I/O burst; look at the next head once
            if (second) begin
              state <= S_CPU;
            end else begin
              second <= 1'b1;
            end
          end else begin
            io_addr <= mem_raddr;
            state   <= S_IORD;
          end
        end
        S_IORD: begin
          if (mem_rdata == '0 && !second) begin
            second <= 1'b1;
            state  <= S_IOCHK;
          end else begin
            state <= S_CPU;
          end
        end
        S_CPU: begin
          if (runner == IDLE_SLOT) begin
            cpu_live <= 1'b0;
            r_busy   <= 1'b0;
            r_label  <= '0;
            state    <= S_DONE;
          end else begin
            r_busy   <= 1'b1;
            r_label  <= rec_label;
            cpu_addr <= mem_raddr;
            state    <= S_CPURD;
          end
        end
        S_CPURD: begin
          if (run_ticks != 16'hFFFF) begin
            run_ticks <= run_ticks + 16'd1;
          end
          cpu_live <= !cpu_end;
          state    <= S_DONE;
        end
        S_DONE: begin
          // hold the finished word until the output register frees up
          if (!out_valid || !out_stall) begin
            if (tick_count != 16'hFFFF) begin
              tick_count <= tick_count + 16'd1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      cpu_busy       <= r_busy;
      run_label      <= r_label;
      segment_end    <= r_seg;
      segment_label  <= r_seg_label;
      segment_length <= r_seg_len;
      all_done       <= r_done;
    end
  end

endmodule

### tb/sv/tb_shortest_burst_cpu_scheduler.sv
// Self-checking testbench for the shortest-burst CPU scheduler: directed table, then random jobs.
module tb_shortest_burst_cpu_scheduler;

  localparam int NPROC = 16;
  localparam int NBURST = 128;
  localparam int QDEPTH = 16;
  localparam int IDLE = NPROC;
  localparam int SPAN = 2 * QDEPTH;
  localparam int ITEM_GOAL = 1650;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 40;
  localparam logic [1:0] REQ_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  req;
    logic [3:0]  slot;
    logic [6:0]  bidx;
    logic [15:0] bval;
    logic [15:0] arrive;
    logic [7:0]  label;
    logic [7:0]  count;
  } word_t;

  typedef struct packed {
    logic        cpu_busy;
    logic [7:0]  run_label;
    logic        segment_end;
    logic [7:0]  segment_label;
    logic [15:0] segment_length;
    logic        all_done;
  } sched_t;

  typedef struct {
    bit     is_cfg;
    bit     preempt;
    int     procs;
    word_t  w;
    bit     typed;
    sched_t res;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [4:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] req_type = 0;
  logic [3:0] slot = 0;
  logic [6:0] burst_index = 0;
  logic [15:0] burst_value = 0;
  logic [15:0] arrival_time = 0;
  logic [7:0] proc_label = 0;
  logic [7:0] burst_count = 0;
  logic out_valid;
  logic out_stall = 0;
  logic cpu_busy;
  logic [7:0] run_label;
  logic segment_end;
  logic [7:0] segment_label;
  logic [15:0] segment_length;
  logic all_done;

  shortest_burst_cpu_scheduler uut (.*);

  always #5 clk = ~clk;

  // scheduler shadow state
  logic [15:0] burst_mem [NPROC][NBURST];
  int unsigned bptr [NPROC];
  int unsigned btot [NPROC];
  logic [15:0] arr_tick [NPROC];
  logic [7:0] lbl [NPROC];
  bit ready [NPROC];
  int unsigned io_q [QDEPTH];
  int unsigned io_rd, io_wr, now_tick, runner, run_len;
  bit live;
  bit preempt_on;
  int unsigned procs_cfg;

  int loaded_len [NPROC];  // burst entries 0..n-1 written per slot
  sched_t sched_q [$];
  int items = 0;
  int cycles = 0;
  int tx_pct = 0;
  int rx_pct = 0;
  int hold_req = 0;
  bit failed = 0;

  function automatic int unsigned used_slots();
    return procs_cfg > NPROC ? NPROC : procs_cfg;
  endfunction

  function automatic bit pending(int unsigned s);
    return bptr[s] < btot[s];
  endfunction

  function automatic int unsigned q_len();
    return (io_wr + SPAN - io_rd) % SPAN;
  endfunction

  function automatic void q_release();
    int unsigned s;
    s = io_q[io_rd % QDEPTH] % NPROC;
    ready[s] = 1;
    if (pending(s)) bptr[s]++;
    io_rd = (io_rd + 1) % SPAN;
  endfunction

  function automatic bit io_done_now(int unsigned s);
    if (!pending(s)) return 1;
    return burst_mem[s][bptr[s]] == 0;
  endfunction

  // count down the I/O head; a zero-length head releases at once and the next one counts
  function automatic void io_advance();
    int unsigned s;
    if (q_len() == 0) return;
    s = io_q[io_rd % QDEPTH] % NPROC;
    if (io_done_now(s)) begin
      q_release();
      if (q_len() == 0) return;
      s = io_q[io_rd % QDEPTH] % NPROC;
      if (io_done_now(s)) return;
    end
    burst_mem[s][bptr[s]]--;
    if (burst_mem[s][bptr[s]] == 0) q_release();
  endfunction

  function automatic int unsigned shortest_ready();
    int unsigned best, lo;
    best = IDLE;
    lo = 0;
    for (int unsigned i = 0; i < used_slots(); i++) begin
      if (arr_tick[i] <= now_tick && ready[i] && pending(i)) begin
        if (best == IDLE || burst_mem[i][bptr[i]] < lo) begin
          lo = burst_mem[i][bptr[i]];
          best = i;
        end
      end
    end
    return best;
  endfunction

  function automatic bit schedule_word(word_t w, output sched_t r);
    int unsigned c, s;
    bit done;
    r = '0;
    s = w.slot;
    if (w.req == sbcs_pkg::REQ_HEADER) begin
      arr_tick[s] = w.arrive;
      lbl[s] = w.label;
      btot[s] = w.count > NBURST ? NBURST : w.count;
      bptr[s] = 0;
      ready[s] = 1;
      return 0;
    end
    if (w.req == sbcs_pkg::REQ_BURST) begin
      burst_mem[s][w.bidx] = w.bval;
      return 0;
    end
    if (w.req != sbcs_pkg::REQ_TICK) return 0;
    if (!preempt_on && live && runner < NPROC) c = runner;
    else c = shortest_ready();
    if (runner != IDLE && c != runner) begin
      r.segment_end = 1;
      r.segment_label = lbl[runner % NPROC];
      r.segment_length = 16'(run_len);
      run_len = 0;
    end
    runner = c;
    done = 1;
    for (int unsigned i = 0; i < used_slots(); i++)
      if (pending(i)) done = 0;
    r.all_done = done;
    io_advance();
    if (c != IDLE) begin
      r.cpu_busy = 1;
      r.run_label = lbl[c];
      if (run_len < 16'hFFFF) run_len++;
      if (burst_mem[c][bptr[c]] > 0) burst_mem[c][bptr[c]]--;
      if (burst_mem[c][bptr[c]] == 0) begin
        live = 0;
        bptr[c]++;
        if (pending(c)) begin
          if (q_len() < QDEPTH) begin
            io_q[io_wr % QDEPTH] = c;
            io_wr = (io_wr + 1) % SPAN;
            ready[c] = 0;
          end else begin
            // queue full: skip the I/O burst
            bptr[c]++;
          end
        end
      end else begin
        live = 1;
      end
    end else begin
      live = 0;
    end
    if (now_tick < 16'hFFFF) now_tick++;
    return 1;
  endfunction

  function automatic bit all_finished();
    for (int unsigned i = 0; i < used_slots(); i++)
      if (pending(i)) return 0;
    return 1;
  endfunction

  task automatic send_word(word_t w, bit typed, sched_t tv);
    sched_t r;
    if (items < ITEM_GOAL / 3) begin
      tx_pct = 32; rx_pct = 58;
    end else if (items < 2 * ITEM_GOAL / 3) begin
      tx_pct = 58; rx_pct = 32;
    end else begin
      tx_pct = 0; rx_pct = 0;
    end
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    req_type <= w.req;
    slot <= w.slot;
    burst_index <= w.bidx;
    burst_value <= w.bval;
    arrival_time <= w.arrive;
    proc_label <= w.label;
    burst_count <= w.count;
    do @(posedge clk); while (in_stall);
    if (schedule_word(w, r)) sched_q.push_back(typed ? tv : r);
    if (w.req == sbcs_pkg::REQ_BURST && w.bidx == loaded_len[w.slot]) loaded_len[w.slot]++;
    items++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sched_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(bit pre, int procs);
    cfg_we <= 1;
    cfg_index <= sbcs_pkg::CFG_PREEMPT;
    cfg_data <= {4'd0, pre};
    @(posedge clk);
    cfg_index <= sbcs_pkg::CFG_PROC_COUNT;
    cfg_data <= procs[4:0];
    @(posedge clk);
    cfg_we <= 0;
    preempt_on = pre;
    procs_cfg = procs;
  endtask

  function automatic word_t mk(logic [1:0] rq, int s, int bi, int bv, int at, int lb, int cn);
    word_t w;
    w.req = rq; w.slot = 4'(s); w.bidx = 7'(bi); w.bval = 16'(bv);
    w.arrive = 16'(at); w.label = 8'(lb); w.count = 8'(cn);
    return w;
  endfunction

  function automatic word_t rand_word(logic [1:0] rq);
    return mk(rq, $urandom_range(15), $urandom_range(127), $urandom_range(16'hFFFF),
              $urandom_range(16'hFFFF), $urandom_range(255), $urandom_range(255));
  endfunction

  function automatic logic [15:0] rand_burst();
    int p;
    p = $urandom_range(99);
    if (p < 2) return 16'($urandom_range(16'hFFFF));
    if (p < 10) return 16'($urandom_range(40));
    return 16'($urandom_range(6));
  endfunction

  function automatic logic [15:0] rand_arrival();
    int unsigned a;
    if ($urandom_range(99) < 8) return 16'($urandom_range(16'hFFFF));
    a = now_tick + $urandom_range(20);
    return a > 16'hFFFF ? 16'hFFFF : 16'(a);
  endfunction

  task automatic random_job(bit pre, int procs, bit long_hold);
    int cnt, n, ticks;
    sched_t none;
    word_t w;
    none = '0;
    drain();
    write_cfg(pre, procs);
    for (int s = 0; s < NPROC; s++) begin
      cnt = ($urandom_range(99) < 3) ? $urandom_range(128, 255) : $urandom_range(7);
      n = cnt > NBURST ? NBURST : cnt;
      if (n < 1) n = 1;
      // write bursts before the header so no unwritten entry is ever current
      for (int b = 0; b < n; b++)
        send_word(mk(sbcs_pkg::REQ_BURST, s, b, rand_burst(), 0, 0, 0), 0, none);
      send_word(mk(sbcs_pkg::REQ_HEADER, s, 0, 0, rand_arrival(), $urandom_range(255), cnt),
                0, none);
    end
    if (long_hold) hold_req = 1;
    ticks = 0;
    while (ticks < 80 && !(ticks >= 3 && all_finished())) begin
      case ($urandom_range(24))
        0: begin
          n = $urandom_range(NPROC - 1);
          cnt = $urandom_range(1, loaded_len[n] < 9 ? loaded_len[n] : 9);
          send_word(mk(sbcs_pkg::REQ_HEADER, n, 0, 0, rand_arrival(), $urandom_range(255), cnt),
                    0, none);
        end
        1: begin
          n = $urandom_range(NPROC - 1);
          w = mk(sbcs_pkg::REQ_BURST, n, 0, rand_burst(), 0, 0, 0);
          w.bidx = loaded_len[n] < NBURST ? 7'($urandom_range(loaded_len[n]))
                                          : 7'($urandom_range(127));
          send_word(w, 0, none);
        end
        2: begin
          w = rand_word(REQ_NONE);
          send_word(w, 0, none);
        end
        default: begin
          w = rand_word(sbcs_pkg::REQ_TICK);
          send_word(w, 0, none);
          ticks++;
        end
      endcase
    end
  endtask

  // receiver: random stall, one long hold-off on request
  always @(posedge clk) begin
    static int hold_left = 0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (sched_q.size() == 0) begin
          $error("result word with nothing expected");
          failed = 1;
        end else begin
          sched_t e;
          e = sched_q.pop_front();
          if (cpu_busy !== e.cpu_busy) begin
            $error("cpu_busy exp %0d got %0d", e.cpu_busy, cpu_busy); failed = 1;
          end
          if (run_label !== e.run_label) begin
            $error("run_label exp %0d got %0d", e.run_label, run_label); failed = 1;
          end
          if (segment_end !== e.segment_end) begin
            $error("segment_end exp %0d got %0d", e.segment_end, segment_end); failed = 1;
          end
          if (segment_label !== e.segment_label) begin
            $error("segment_label exp %0d got %0d", e.segment_label, segment_label); failed = 1;
          end
          if (segment_length !== e.segment_length) begin
            $error("segment_length exp %0d got %0d", e.segment_length, segment_length);
            failed = 1;
          end
          if (all_done !== e.all_done) begin
            $error("all_done exp %0d got %0d", e.all_done, all_done); failed = 1;
          end
        end
      end
      if (hold_req != 0) begin
        hold_left = 400;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    row_t tab [$];
    row_t r;
    sched_t none;
    int phase;
    none = '0;
    for (int s = 0; s < NPROC; s++) begin
      bptr[s] = 0; btot[s] = 0; ready[s] = 1; loaded_len[s] = 0;
      arr_tick[s] = 0; lbl[s] = 0;
    end
    io_rd = 0; io_wr = 0; now_tick = 0; runner = IDLE; run_len = 0; live = 0;
    preempt_on = 1; procs_cfg = 0;

    // directed table
    r = '{default: '0};
    // no slots in use: idle CPU, everything done
    r.w = mk(sbcs_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0); r.typed = 1;
    r.res = '{cpu_busy: 0, run_label: 0, segment_end: 0, segment_label: 0,
              segment_length: 0, all_done: 1};
    tab.push_back(r);
    r = '{default: '0};
    r.w = mk(REQ_NONE, 15, 127, 16'hFFFF, 16'hFFFF, 255, 255);
    tab.push_back(r);
    r = '{default: '0}; r.is_cfg = 1; r.preempt = 1; r.procs = 3; tab.push_back(r);
    r = '{default: '0};
    r.w = mk(sbcs_pkg::REQ_BURST, 0, 0, 2, 0, 0, 0); tab.push_back(r);
    r.w = mk(sbcs_pkg::REQ_BURST, 0, 1, 0, 0, 0, 0); tab.push_back(r);   // zero-length I/O
    r.w = mk(sbcs_pkg::REQ_BURST, 0, 2, 0, 0, 0, 0); tab.push_back(r);   // zero-length CPU
    r.w = mk(sbcs_pkg::REQ_HEADER, 0, 0, 0, 0, 8'hAA, 3); tab.push_back(r);
    r.w = mk(sbcs_pkg::REQ_BURST, 1, 0, 2, 0, 0, 0); tab.push_back(r);
    r.w = mk(sbcs_pkg::REQ_HEADER, 1, 0, 0, 0, 8'h55, 1); tab.push_back(r);
    r.w = mk(sbcs_pkg::REQ_BURST, 2, 0, 5, 0, 0, 0); tab.push_back(r);
    r.w = mk(sbcs_pkg::REQ_HEADER, 2, 0, 0, 16'hFFFF, 255, 0); tab.push_back(r);
    r.w = mk(sbcs_pkg::REQ_BURST, 15, 127, 16'hFFFF, 0, 0, 0); tab.push_back(r);
    // tie on burst 2: lowest slot wins
    r.w = mk(sbcs_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0); r.typed = 1;
    r.res = '{cpu_busy: 1, run_label: 8'hAA, segment_end: 0, segment_label: 0,
              segment_length: 0, all_done: 0};
    tab.push_back(r);
    r.typed = 0;
    repeat (8) tab.push_back(r);
    r = '{default: '0}; r.is_cfg = 1; r.preempt = 0; r.procs = 2; tab.push_back(r);
    r = '{default: '0};
    r.w = mk(sbcs_pkg::REQ_BURST, 0, 0, 3, 0, 0, 0); tab.push_back(r);
    r.w = mk(sbcs_pkg::REQ_HEADER, 0, 0, 0, 0, 8'h0F, 1); tab.push_back(r);
    r.w = mk(sbcs_pkg::REQ_BURST, 1, 0, 1, 0, 0, 0); tab.push_back(r);
    r.w = mk(sbcs_pkg::REQ_HEADER, 1, 0, 0, 1, 8'hF0, 1); tab.push_back(r);
    r.w = mk(sbcs_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0);
    repeat (5) tab.push_back(r);

    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (tab[i]) begin
      if (tab[i].is_cfg) begin
        drain();
        write_cfg(tab[i].preempt, tab[i].procs);
      end else begin
        send_word(tab[i].w, tab[i].typed, tab[i].res);
      end
    end

    phase = 0;
    while (items < ITEM_GOAL) begin
      case (phase % 8)
        0: random_job(0, 16, 0);
        1: random_job(1, 16, 1);
        2: random_job(1, 1, 0);
        3: random_job(0, 31, 0);
        4: random_job(1, 0, 0);
        default: random_job($urandom_range(1), $urandom_range(1, 20), 0);
      endcase
      phase++;
    end
    drain();
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
